FILE: hw/rtl/tppd_pkg.sv
// shared types and constants for the three-point pulse despiker
package tppd_pkg;

    // configuration register geometry
    localparam int FLOOR_W   = 40;
    localparam int DIV_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DAY_W     = 32;

    // register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AGREE_FLOOR = 2'd0,
        REG_AGREE_DIV   = 2'd1,
        REG_PULSE_FLOOR = 2'd2,
        REG_PULSE_DIV   = 2'd3
    } cfg_idx_t;

    // reset values of the registers
    localparam logic [FLOOR_W-1:0] AGREE_FLOOR_RST = 40'd15000;
    localparam logic [DIV_W-1:0]   AGREE_DIV_RST   = 16'd100;
    localparam logic [FLOOR_W-1:0] PULSE_FLOOR_RST = 40'd5000;
    localparam logic [DIV_W-1:0]   PULSE_DIV_RST   = 16'd200;

    // window fill codes
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    // effective settings, divisors already forced nonzero
    typedef struct packed {
        logic [FLOOR_W-1:0] agree_floor;
        logic [DIV_W-1:0]   agree_div;
        logic [FLOOR_W-1:0] pulse_floor;
        logic [DIV_W-1:0]   pulse_div;
    } cfg_t;

    // request control leaving the window stage
    typedef struct packed {
        logic has_pri;   // middle sample is emitted
        logic has_sec;   // final sample of the series is emitted
        logic chk;       // middle has two real neighbours
    } job_ctl_t;

    // request control leaving the judge stages
    typedef struct packed {
        logic has_pri;
        logic has_sec;
        logic cand;          // full window and middle protrudes one way
        logic agree_floor_ok;
        logic pulse_floor_ok;
    } judge_t;

endpackage

FILE: hw/rtl/three_point_pulse_despiker_core.sv
// top level of the three-point pulse despiker
// Streaming despiker for dated balance samples. One sample is accepted per
// clock while the pipeline is not held by output back-pressure or a pending
// second result; each result passes through the input register, distance
// stage, threshold product stage and result register. The result for a
// sample is released by the next sample of the series, and the final sample
// of a series releases two results, which occupy the result register one
// after the other. A middle sample is replaced by the floored mean
// of its original neighbours when it protrudes above or below both of them,
// the neighbours agree within the agreement tolerance and the smaller
// protrusion reaches the pulse threshold; the scaled tolerances compare
// products of distance and divisor against the larger neighbour magnitude,
// so no divider is used. Configuration writes take effect at once and must
// only be issued while no request is in flight; a divisor of zero acts as one.
module three_point_pulse_despiker_core #(
    parameter int SAMPLE_BITS = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tppd_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [tppd_pkg::FLOOR_W-1:0]   cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tppd_pkg::DAY_W-1:0]     s_day_stamp,
    input  logic [SAMPLE_BITS-1:0]         s_balance,
    input  logic                           s_series_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tppd_pkg::DAY_W-1:0]     m_out_day,
    output logic [SAMPLE_BITS-1:0]         m_out_balance,
    output logic                           m_was_corrected,
    output logic                           m_out_last
);
    import tppd_pkg::*;

    localparam int SB = SAMPLE_BITS;

    cfg_t             cfg;

    logic             j_valid, j_ready;
    job_ctl_t         j_ctl;
    logic [SB-1:0]    j_a, j_b, j_c;
    logic [DAY_W-1:0] j_pday, j_sday;

    logic             k_valid, k_ready;
    judge_t           k_flags;
    logic [SB-1:0]    k_b, k_c, k_mean, k_mag;
    logic [SB+DIV_W-1:0] k_prod_agree;
    logic [SB+DIV_W:0]   k_prod_pulse;
    logic [DAY_W-1:0] k_pday, k_sday;

    // configuration registers
    tppd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sample window
    tppd_window #(.SAMPLE_BITS(SB)) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_day_stamp  (s_day_stamp),
        .s_balance    (s_balance),
        .s_series_end (s_series_end),
        .j_valid      (j_valid),
        .j_ready      (j_ready),
        .j_ctl        (j_ctl),
        .j_a          (j_a),
        .j_b          (j_b),
        .j_c          (j_c),
        .j_pday       (j_pday),
        .j_sday       (j_sday)
    );

    // pulse measurement stages
    tppd_judge #(.SAMPLE_BITS(SB)) u_judge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .j_valid      (j_valid),
        .j_ready      (j_ready),
        .j_ctl        (j_ctl),
        .j_a          (j_a),
        .j_b          (j_b),
        .j_c          (j_c),
        .j_pday       (j_pday),
        .j_sday       (j_sday),
        .k_valid      (k_valid),
        .k_ready      (k_ready),
        .k_flags      (k_flags),
        .k_b          (k_b),
        .k_c          (k_c),
        .k_mean       (k_mean),
        .k_mag        (k_mag),
        .k_prod_agree (k_prod_agree),
        .k_prod_pulse (k_prod_pulse),
        .k_pday       (k_pday),
        .k_sday       (k_sday)
    );

    // result register
    tppd_out #(.SAMPLE_BITS(SB)) u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .k_valid         (k_valid),
        .k_ready         (k_ready),
        .k_flags         (k_flags),
        .k_b             (k_b),
        .k_c             (k_c),
        .k_mean          (k_mean),
        .k_mag           (k_mag),
        .k_prod_agree    (k_prod_agree),
        .k_prod_pulse    (k_prod_pulse),
        .k_pday          (k_pday),
        .k_sday          (k_sday),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_day       (m_out_day),
        .m_out_balance   (m_out_balance),
        .m_was_corrected (m_was_corrected),
        .m_out_last      (m_out_last)
    );

endmodule

FILE: hw/rtl/tppd_cfg.sv
// configuration registers of the despiker
module tppd_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tppd_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [tppd_pkg::FLOOR_W-1:0]  cfg_wdata,
    output tppd_pkg::cfg_t                cfg
);
    import tppd_pkg::*;

    logic [FLOOR_W-1:0] agree_floor_reg;
    logic [DIV_W-1:0]   agree_div_reg;
    logic [FLOOR_W-1:0] pulse_floor_reg;
    logic [DIV_W-1:0]   pulse_div_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            agree_floor_reg <= AGREE_FLOOR_RST;
            agree_div_reg   <= AGREE_DIV_RST;
            pulse_floor_reg <= PULSE_FLOOR_RST;
            pulse_div_reg   <= PULSE_DIV_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_idx))
                REG_AGREE_FLOOR: agree_floor_reg <= cfg_wdata;
                REG_AGREE_DIV:   agree_div_reg   <= cfg_wdata[DIV_W-1:0];
                REG_PULSE_FLOOR: pulse_floor_reg <= cfg_wdata;
                REG_PULSE_DIV:   pulse_div_reg   <= cfg_wdata[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero divisor acts as one
    always_comb begin
        cfg.agree_floor = agree_floor_reg;
        cfg.agree_div   = (agree_div_reg == '0) ? DIV_W'(1) : agree_div_reg;
        cfg.pulse_floor = pulse_floor_reg;
        cfg.pulse_div   = (pulse_div_reg == '0) ? DIV_W'(1) : pulse_div_reg;
    end

endmodule

FILE: hw/rtl/tppd_window.sv
// sample window and input register of the despiker
module tppd_window #(
    parameter int SAMPLE_BITS = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tppd_pkg::DAY_W-1:0]  s_day_stamp,
    input  logic [SAMPLE_BITS-1:0]      s_balance,
    input  logic                        s_series_end,
    output logic                        j_valid,
    input  logic                        j_ready,
    output tppd_pkg::job_ctl_t          j_ctl,
    output logic [SAMPLE_BITS-1:0]      j_a,
    output logic [SAMPLE_BITS-1:0]      j_b,
    output logic [SAMPLE_BITS-1:0]      j_c,
    output logic [tppd_pkg::DAY_W-1:0]  j_pday,
    output logic [tppd_pkg::DAY_W-1:0]  j_sday
);
    import tppd_pkg::*;

    logic [SAMPLE_BITS-1:0] older_reg, older_next;
    logic [SAMPLE_BITS-1:0] middle_reg, middle_next;
    logic [DAY_W-1:0]       mday_reg, mday_next;
    logic [1:0]             seen_reg, seen_next;

    logic                   v1_reg, v1_next;
    job_ctl_t               ctl1_reg, ctl_new;
    logic                   job_new;
    logic [SAMPLE_BITS-1:0] a1_reg, b1_reg, c1_reg;
    logic [DAY_W-1:0]       pday1_reg, sday1_reg;
    logic                   accept;

    assign s_ready = !v1_reg || j_ready;
    assign accept  = s_valid && s_ready;

    // window update and request forming
    always_comb begin
        older_next  = older_reg;
        middle_next = middle_reg;
        mday_next   = mday_reg;
        seen_next   = seen_reg;
        job_new     = 1'b0;
        ctl_new     = '0;
        if (accept) begin
            if (seen_reg == SEEN_NONE) begin
                if (s_series_end) begin
                    job_new         = 1'b1;
                    ctl_new.has_sec = 1'b1;
                end else begin
                    middle_next = s_balance;
                    mday_next   = s_day_stamp;
                    seen_next   = SEEN_ONE;
                end
            end else begin
                job_new         = 1'b1;
                ctl_new.has_pri = 1'b1;
                ctl_new.has_sec = s_series_end;
                ctl_new.chk     = (seen_reg == SEEN_TWO);
                if (s_series_end) begin
                    older_next  = '0;
                    middle_next = '0;
                    mday_next   = '0;
                    seen_next   = SEEN_NONE;
                end else begin
                    older_next  = middle_reg;
                    middle_next = s_balance;
                    mday_next   = s_day_stamp;
                    seen_next   = SEEN_TWO;
                end
            end
        end
    end

    // input register advances whenever downstream has room
    always_comb begin
        v1_next = v1_reg;
        if (s_ready) begin
            v1_next = job_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg  <= '0;
            middle_reg <= '0;
            mday_reg   <= '0;
            seen_reg   <= SEEN_NONE;
            v1_reg     <= 1'b0;
        end else begin
            older_reg  <= older_next;
            middle_reg <= middle_next;
            mday_reg   <= mday_next;
            seen_reg   <= seen_next;
            v1_reg     <= v1_next;
        end
    end

    // window snapshot of the request
    always_ff @(posedge aclk) begin
        if (accept && job_new) begin
            ctl1_reg  <= ctl_new;
            a1_reg    <= older_reg;
            b1_reg    <= middle_reg;
            c1_reg    <= s_balance;
            pday1_reg <= mday_reg;
            sday1_reg <= s_day_stamp;
        end
    end

    assign j_valid = v1_reg;
    assign j_ctl   = ctl1_reg;
    assign j_a     = a1_reg;
    assign j_b     = b1_reg;
    assign j_c     = c1_reg;
    assign j_pday  = pday1_reg;
    assign j_sday  = sday1_reg;

    // fill count never goes past two
    a_seen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg != 2'd3)
        else $error("window fill count out of range");

    // a series end empties the window
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_series_end) |=> (seen_reg == SEEN_NONE))
        else $error("window not emptied after series end");

    // a first sample alone never makes a request unless it ends the series
    a_first_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_series_end && seen_reg == SEEN_NONE && !v1_reg) |=> !v1_reg)
        else $error("request made from a lone first sample");

endmodule

FILE: hw/rtl/tppd_judge.sv
// distance, magnitude and threshold product stages of the despiker
module tppd_judge #(
    parameter int SAMPLE_BITS = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tppd_pkg::cfg_t              cfg,
    input  logic                        j_valid,
    output logic                        j_ready,
    input  tppd_pkg::job_ctl_t          j_ctl,
    input  logic [SAMPLE_BITS-1:0]      j_a,
    input  logic [SAMPLE_BITS-1:0]      j_b,
    input  logic [SAMPLE_BITS-1:0]      j_c,
    input  logic [tppd_pkg::DAY_W-1:0]  j_pday,
    input  logic [tppd_pkg::DAY_W-1:0]  j_sday,
    output logic                        k_valid,
    input  logic                        k_ready,
    output tppd_pkg::judge_t            k_flags,
    output logic [SAMPLE_BITS-1:0]      k_b,
    output logic [SAMPLE_BITS-1:0]      k_c,
    output logic [SAMPLE_BITS-1:0]      k_mean,
    output logic [SAMPLE_BITS-1:0]      k_mag,
    output logic [SAMPLE_BITS+tppd_pkg::DIV_W-1:0]   k_prod_agree,
    output logic [SAMPLE_BITS+tppd_pkg::DIV_W:0]     k_prod_pulse,
    output logic [tppd_pkg::DAY_W-1:0]  k_pday,
    output logic [tppd_pkg::DAY_W-1:0]  k_sday
);
    import tppd_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int PA_W = SB + DIV_W;
    localparam int PP_W = SB + DIV_W + 1;
    localparam int CMPW = (SB > FLOOR_W) ? SB : FLOOR_W;

    // stage 2 registers
    logic           v2_reg, v2_next;
    job_ctl_t       ctl2_reg;
    logic           dir2_reg;
    logic [SB-1:0]  b2_reg, c2_reg, mean2_reg, mag2_reg, dac2_reg, dmin2_reg;
    logic [DAY_W-1:0] pday2_reg, sday2_reg;

    // stage 3 registers
    logic           v3_reg, v3_next;
    judge_t         flags3_reg, flags3_new;
    logic [SB-1:0]  b3_reg, c3_reg, mean3_reg, mag3_reg;
    logic [PA_W-1:0] pa3_reg;
    logic [PP_W-1:0] pp3_reg;
    logic [DAY_W-1:0] pday3_reg, sday3_reg;

    logic           ready2, ready3;

    // stage 2 combinational
    logic signed [SB:0] d_ba, d_bc, d_ac, sum_ac;
    logic [SB-1:0]      dist_ba, dist_bc, dist_ac, mag_a, mag_c;
    logic               up, down;

    assign ready3  = !v3_reg || k_ready;
    assign ready2  = !v2_reg || ready3;
    assign j_ready = ready2;

    // distances, magnitudes, direction and neighbour mean
    always_comb begin
        d_ba    = $signed({j_b[SB-1], j_b}) - $signed({j_a[SB-1], j_a});
        d_bc    = $signed({j_b[SB-1], j_b}) - $signed({j_c[SB-1], j_c});
        d_ac    = $signed({j_a[SB-1], j_a}) - $signed({j_c[SB-1], j_c});
        sum_ac  = $signed({j_a[SB-1], j_a}) + $signed({j_c[SB-1], j_c});
        dist_ba = d_ba[SB] ? SB'(-d_ba) : d_ba[SB-1:0];
        dist_bc = d_bc[SB] ? SB'(-d_bc) : d_bc[SB-1:0];
        dist_ac = d_ac[SB] ? SB'(-d_ac) : d_ac[SB-1:0];
        mag_a   = j_a[SB-1] ? (~j_a + SB'(1)) : j_a;
        mag_c   = j_c[SB-1] ? (~j_c + SB'(1)) : j_c;
        up      = ($signed(j_b) > $signed(j_a)) && ($signed(j_b) > $signed(j_c));
        down    = ($signed(j_b) < $signed(j_a)) && ($signed(j_b) < $signed(j_c));
    end

    always_comb begin
        v2_next = v2_reg;
        if (ready2) begin
            v2_next = j_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && j_valid) begin
            ctl2_reg  <= j_ctl;
            dir2_reg  <= up || down;
            b2_reg    <= j_b;
            c2_reg    <= j_c;
            mean2_reg <= sum_ac[SB:1];
            mag2_reg  <= (mag_a > mag_c) ? mag_a : mag_c;
            dac2_reg  <= dist_ac;
            dmin2_reg <= (dist_ba < dist_bc) ? dist_ba : dist_bc;
            pday2_reg <= j_pday;
            sday2_reg <= j_sday;
        end
    end

    // floor compares; products replace division by the divisors
    always_comb begin
        flags3_new.has_pri        = ctl2_reg.has_pri;
        flags3_new.has_sec        = ctl2_reg.has_sec;
        flags3_new.cand           = ctl2_reg.chk && dir2_reg;
        flags3_new.agree_floor_ok = CMPW'(dac2_reg) <= CMPW'(cfg.agree_floor);
        flags3_new.pulse_floor_ok = CMPW'(dmin2_reg) >= CMPW'(cfg.pulse_floor);
    end

    always_comb begin
        v3_next = v3_reg;
        if (ready3) begin
            v3_next = v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3 && v2_reg) begin
            flags3_reg <= flags3_new;
            b3_reg     <= b2_reg;
            c3_reg     <= c2_reg;
            mean3_reg  <= mean2_reg;
            mag3_reg   <= mag2_reg;
            pa3_reg    <= PA_W'(dac2_reg) * PA_W'(cfg.agree_div);
            pp3_reg    <= (PP_W'(dmin2_reg) + PP_W'(1)) * PP_W'(cfg.pulse_div);
            pday3_reg  <= pday2_reg;
            sday3_reg  <= sday2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign k_valid      = v3_reg;
    assign k_flags      = flags3_reg;
    assign k_b          = b3_reg;
    assign k_c          = c3_reg;
    assign k_mean       = mean3_reg;
    assign k_mag        = mag3_reg;
    assign k_prod_agree = pa3_reg;
    assign k_prod_pulse = pp3_reg;
    assign k_pday       = pday3_reg;
    assign k_sday       = sday3_reg;

endmodule

FILE: hw/rtl/tppd_out.sv
// result register and second-result buffer of the despiker
module tppd_out #(
    parameter int SAMPLE_BITS = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        k_valid,
    output logic                        k_ready,
    input  tppd_pkg::judge_t            k_flags,
    input  logic [SAMPLE_BITS-1:0]      k_b,
    input  logic [SAMPLE_BITS-1:0]      k_c,
    input  logic [SAMPLE_BITS-1:0]      k_mean,
    input  logic [SAMPLE_BITS-1:0]      k_mag,
    input  logic [SAMPLE_BITS+tppd_pkg::DIV_W-1:0]   k_prod_agree,
    input  logic [SAMPLE_BITS+tppd_pkg::DIV_W:0]     k_prod_pulse,
    input  logic [tppd_pkg::DAY_W-1:0]  k_pday,
    input  logic [tppd_pkg::DAY_W-1:0]  k_sday,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tppd_pkg::DAY_W-1:0]  m_out_day,
    output logic [SAMPLE_BITS-1:0]      m_out_balance,
    output logic                        m_was_corrected,
    output logic                        m_out_last
);
    import tppd_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int PA_W = SB + DIV_W;
    localparam int PP_W = SB + DIV_W + 1;

    logic             m_valid_reg, m_valid_next;
    logic             sec_pending_reg, sec_pending_next;
    logic [DAY_W-1:0] day_reg, day_next;
    logic [SB-1:0]    bal_reg, bal_next;
    logic             corr_reg, corr_next;
    logic             last_reg, last_next;
    logic [DAY_W-1:0] sec_day_reg, sec_day_next;
    logic [SB-1:0]    sec_bal_reg, sec_bal_next;
    logic             slot_free;
    logic             fix;

    assign slot_free = !m_valid_reg || m_ready;
    assign k_ready   = slot_free && !sec_pending_reg;

    // final pulse decision
    assign fix = k_flags.cand && k_flags.pulse_floor_ok
              && (k_flags.agree_floor_ok || (k_prod_agree <= PA_W'(k_mag)))
              && (k_prod_pulse > PP_W'(k_mag));

    // result slot loading
    always_comb begin
        m_valid_next     = m_valid_reg;
        sec_pending_next = sec_pending_reg;
        day_next         = day_reg;
        bal_next         = bal_reg;
        corr_next        = corr_reg;
        last_next        = last_reg;
        sec_day_next     = sec_day_reg;
        sec_bal_next     = sec_bal_reg;
        if (slot_free) begin
            m_valid_next = 1'b0;
            if (sec_pending_reg) begin
                m_valid_next     = 1'b1;
                sec_pending_next = 1'b0;
                day_next         = sec_day_reg;
                bal_next         = sec_bal_reg;
                corr_next        = 1'b0;
                last_next        = 1'b1;
            end else if (k_valid) begin
                m_valid_next = 1'b1;
                if (k_flags.has_pri) begin
                    day_next         = k_pday;
                    bal_next         = fix ? k_mean : k_b;
                    corr_next        = fix;
                    last_next        = 1'b0;
                    sec_pending_next = k_flags.has_sec;
                    sec_day_next     = k_sday;
                    sec_bal_next     = k_c;
                end else begin
                    day_next  = k_sday;
                    bal_next  = k_c;
                    corr_next = 1'b0;
                    last_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            sec_pending_reg <= 1'b0;
        end else begin
            m_valid_reg     <= m_valid_next;
            sec_pending_reg <= sec_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        day_reg     <= day_next;
        bal_reg     <= bal_next;
        corr_reg    <= corr_next;
        last_reg    <= last_next;
        sec_day_reg <= sec_day_next;
        sec_bal_reg <= sec_bal_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_day       = day_reg;
    assign m_out_balance   = bal_reg;
    assign m_was_corrected = corr_reg;
    assign m_out_last      = last_reg;

    // a buffered final sample always sits behind a shown result
    a_sec_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_pending_reg |-> m_valid_reg)
        else $error("second result buffered with empty slot");

    // no new request while the final sample waits
    a_sec_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_pending_reg |-> !k_ready)
        else $error("request taken while second result pending");

    // the series end sample is never a corrected one
    a_last_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(corr_reg && last_reg))
        else $error("final sample marked corrected");

    // a buffered final sample is shown right after its partner leaves
    a_sec_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (sec_pending_reg && m_ready) |=> (m_valid_reg && last_reg))
        else $error("second result not shown after first");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the three-point pulse despiker core
module testbench;
    import tppd_pkg::*;

    localparam int     SAMPLE_BITS = 48;
    localparam int     DRAIN_SLACK = 8;   // four pipeline stages plus margin
    localparam longint BAL_MAX     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint BAL_MIN     = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam logic [FLOOR_W-1:0] FLOOR_ALL_ONES = '1;
    localparam logic [FLOOR_W-1:0] FLOOR_TOP      = 40'd1000000000000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // one emitted sample as the core should deliver it
    typedef struct {
        logic [DAY_W-1:0]       day;
        logic [SAMPLE_BITS-1:0] bal;
        logic                   fixed;
        logic                   last;
    } despiked_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [FLOOR_W-1:0]     cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [DAY_W-1:0]       s_day_stamp;
    logic [SAMPLE_BITS-1:0] s_balance;
    logic                   s_series_end;
    logic                   m_valid;
    logic                   m_ready;
    logic [DAY_W-1:0]       m_out_day;
    logic [SAMPLE_BITS-1:0] m_out_balance;
    logic                   m_was_corrected;
    logic                   m_out_last;

    // shadow of the configuration registers
    logic [FLOOR_W-1:0] agree_floor_q;
    logic [DIV_W-1:0]   agree_div_q;
    logic [FLOOR_W-1:0] pulse_floor_q;
    logic [DIV_W-1:0]   pulse_div_q;

    // shadow of the sample window
    longint           win_older;
    longint           win_middle;
    logic [DAY_W-1:0] win_day;
    logic [1:0]       win_fill;

    despiked_t expected_out[$];
    int        fail_count = 0;
    int        gap_pct    = 0;
    int        stall_pct  = 0;

    three_point_pulse_despiker_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_day_stamp    (s_day_stamp),
        .s_balance      (s_balance),
        .s_series_end   (s_series_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_day      (m_out_day),
        .m_out_balance  (m_out_balance),
        .m_was_corrected(m_was_corrected),
        .m_out_last     (m_out_last)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #(20 * 400000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_balance(input longint v);
        if (v > BAL_MAX) begin
            return BAL_MAX;
        end else if (v < BAL_MIN) begin
            return BAL_MIN;
        end
        return v;
    endfunction

    // neighbour agreement tolerance for a larger neighbour magnitude m
    function automatic longint agree_tol(input longint m);
        longint d;
        longint q;
        d = (agree_div_q == '0) ? 64'sd1 : longint'(agree_div_q);
        q = m / d;
        return (longint'(agree_floor_q) > q) ? longint'(agree_floor_q) : q;
    endfunction

    // smallest protrusion that counts as a pulse
    function automatic longint pulse_need(input longint m);
        longint d;
        longint q;
        d = (pulse_div_q == '0) ? 64'sd1 : longint'(pulse_div_q);
        q = m / d;
        return (longint'(pulse_floor_q) > q) ? longint'(pulse_floor_q) : q;
    endfunction

    // middle b with original neighbours a and c is a removable pulse
    function automatic logic is_despike(input longint a, input longint b, input longint c);
        longint m;
        longint dba;
        longint dbc;
        logic   up;
        logic   down;
        up   = (b > a) && (b > c);
        down = (b < a) && (b < c);
        m    = (mag(a) > mag(c)) ? mag(a) : mag(c);
        dba  = mag(b - a);
        dbc  = mag(b - c);
        if (!up && !down) begin
            return 1'b0;
        end
        return (mag(a - c) <= agree_tol(m)) &&
               (((dba < dbc) ? dba : dbc) >= pulse_need(m));
    endfunction

    function automatic longint rand_below(input longint span);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return longint'(r % span);
    endfunction

    function automatic longint rand_balance();
        logic [SAMPLE_BITS-1:0] r;
        r = SAMPLE_BITS'({$urandom, $urandom});
        return longint'($signed(r));
    endfunction

    // predict the samples released by one accepted request
    task automatic despike_predict(input logic [DAY_W-1:0] day,
                                   input logic [SAMPLE_BITS-1:0] bal,
                                   input logic last);
        despiked_t r;
        longint    x;
        x = longint'($signed(bal));
        if (win_fill == SEEN_NONE) begin
            if (last) begin
                r = '{day, bal, 1'b0, 1'b1};
                expected_out = {expected_out, r};
            end else begin
                win_middle = x;
                win_day    = day;
                win_fill   = SEEN_ONE;
            end
        end else begin
            r = '{win_day, win_middle[SAMPLE_BITS-1:0], 1'b0, 1'b0};
            if (win_fill == SEEN_TWO && is_despike(win_older, win_middle, x)) begin
                r.bal   = SAMPLE_BITS'((win_older + x) >>> 1);
                r.fixed = 1'b1;
            end
            expected_out = {expected_out, r};
            if (last) begin
                r = '{day, bal, 1'b0, 1'b1};
                expected_out = {expected_out, r};
                win_older  = 0;
                win_middle = 0;
                win_day    = '0;
                win_fill   = SEEN_NONE;
            end else begin
                win_older  = win_middle;
                win_middle = x;
                win_day    = day;
                win_fill   = SEEN_TWO;
            end
        end
    endtask

    // offer one request, with a random gap first, and predict on acceptance
    task automatic send_sample(input logic [DAY_W-1:0] day, input longint bal,
                               input logic last);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_day_stamp  <= day;
        s_balance    <= bal[SAMPLE_BITS-1:0];
        s_series_end <= last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        despike_predict(day, bal[SAMPLE_BITS-1:0], last);
    endtask

    // stop offering and let every predicted sample come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (expected_out.size() != 0);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [FLOOR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_AGREE_FLOOR: agree_floor_q = value;
            REG_AGREE_DIV:   agree_div_q   = value[DIV_W-1:0];
            REG_PULSE_FLOOR: pulse_floor_q = value;
            REG_PULSE_DIV:   pulse_div_q   = value[DIV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [FLOOR_W-1:0] af, input logic [FLOOR_W-1:0] ad,
                                input logic [FLOOR_W-1:0] pf, input logic [FLOOR_W-1:0] pd);
        write_reg(REG_AGREE_FLOOR, af);
        write_reg(REG_AGREE_DIV, ad);
        write_reg(REG_PULSE_FLOOR, pf);
        write_reg(REG_PULSE_DIV, pd);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin gap_pct = 47; stall_pct = 0;  end
            IDLE_RECV: begin gap_pct = 0;  stall_pct = 47; end
            default:   begin gap_pct = 38; stall_pct = 38; end
        endcase
    endtask

    function automatic logic [FLOOR_W-1:0] pick_floor();
        logic [FLOOR_W-1:0] r;
        r = FLOOR_W'({$urandom, $urandom});
        case ($urandom_range(5))
            0:       return '0;
            1:       return FLOOR_TOP;
            2:       return r;
            default: return FLOOR_W'($urandom_range(100000));
        endcase
    endfunction

    function automatic logic [FLOOR_W-1:0] pick_div();
        logic [FLOOR_W-1:0] r;
        r = FLOOR_W'({$urandom, $urandom});
        case ($urandom_range(5))
            0:       return '0;
            1:       return 40'd65535;
            2:       return 40'd1;
            3:       return r;
            default: return FLOOR_W'($urandom_range(500, 1));
        endcase
    endfunction

    // random series: mostly flat baselines with spikes near the thresholds
    task automatic run_random_series(input int item_budget);
        int               sent;
        int               len;
        int               shape;
        longint           base;
        longint           tol;
        longint           need;
        longint           spike;
        longint           v;
        logic [DAY_W-1:0] day;
        sent = 0;
        while (sent < item_budget) begin
            case ($urandom_range(19))
                0:       len = $urandom_range(40, 21);
                1, 2, 3: len = $urandom_range(20, 7);
                default: len = $urandom_range(6, 1);
            endcase
            shape = $urandom_range(9);
            day   = $urandom;
            case ($urandom_range(2))
                0:       base = rand_below(2000001) - 1000000;
                1:       base = rand_below(64'sd200000000001) - 64'sd100000000000;
                default: base = rand_balance();
            endcase
            tol  = agree_tol(mag(base));
            need = pulse_need(mag(base));
            for (int k = 0; k < len; k++) begin
                if (shape < 2) begin
                    v = rand_balance();
                end else begin
                    v = base + rand_below(tol + 1) - tol / 2;
                    if ($urandom_range(9) == 0) begin
                        v = v + rand_below(2 * tol + 3) - tol - 1;
                    end
                    if ($urandom_range(3) == 0) begin
                        if ($urandom_range(1) == 0) begin
                            spike = need + rand_below(need + 1);
                        end else begin
                            spike = need + $urandom_range(2) - 1;
                        end
                        v = ($urandom_range(1) == 0) ? v + spike : v - spike;
                    end
                end
                send_sample(day, clamp_balance(v), k == len - 1);
                day  = day + 32'd86400;
                sent = sent + 1;
            end
        end
    endtask

    // reset settings: lone sample, upward pulses, a downward near miss, extremes
    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        send_sample(32'hFFFF_FFFF, BAL_MAX, 1'b1);
        send_sample(32'd100, 100000, 1'b0);
        send_sample(32'd101, 110000, 1'b0);
        send_sample(32'd102, 100003, 1'b0);
        send_sample(32'd103, 96000, 1'b0);
        send_sample(32'd104, 100002, 1'b0);
        send_sample(32'd105, 100002, 1'b0);
        send_sample(32'd106, 100002, 1'b1);
        send_sample(32'h8000_0000, BAL_MIN, 1'b0);
        send_sample(32'h7FFF_FFFF, BAL_MAX, 1'b0);
        send_sample(32'h5555_5555, BAL_MIN, 1'b0);
        send_sample(32'hAAAA_AAAA, -3, 1'b0);
        send_sample(32'h0000_0001, 10000, 1'b0);
        send_sample(32'hFFFF_FFFE, -4, 1'b1);
        send_sample(32'd0, 0, 1'b0);
        send_sample(32'd1, -1, 1'b1);
        wait_idle();
    endtask

    // zero divisors act as one; largest floors and divisors
    task automatic test_register_extremes();
        set_idling(IDLE_NONE);
        write_config('0, '0, '0, '0);
        send_sample(32'd7, 0, 1'b0);
        send_sample(32'd8, 1, 1'b0);
        send_sample(32'd9, 0, 1'b1);
        wait_idle();
        write_config(FLOOR_ALL_ONES, 40'd65535, FLOOR_ALL_ONES, 40'd65535);
        send_sample(32'd10, 0, 1'b0);
        send_sample(32'd11, longint'(FLOOR_ALL_ONES), 1'b0);
        send_sample(32'd12, 0, 1'b0);
        send_sample(32'd13, longint'(FLOOR_ALL_ONES) - 1, 1'b0);
        send_sample(32'd14, 0, 1'b1);
        wait_idle();
    endtask

    // the sender holds off mid-series until every released sample is out
    task automatic test_pause_mid_series();
        set_idling(IDLE_RECV);
        write_config(AGREE_FLOOR_RST, FLOOR_W'(AGREE_DIV_RST), PULSE_FLOOR_RST,
                     FLOOR_W'(PULSE_DIV_RST));
        send_sample(32'd500, 200000, 1'b0);
        send_sample(32'd501, 200010, 1'b0);
        send_sample(32'd502, 230000, 1'b0);
        send_sample(32'd503, 200005, 1'b0);
        wait_idle();
        send_sample(32'd504, 199990, 1'b0);
        send_sample(32'd505, 170000, 1'b0);
        send_sample(32'd506, 200000, 1'b1);
        wait_idle();
    endtask

    // random streams under changing settings and idling
    task automatic test_random_streams();
        for (int phase = 0; phase < 8; phase++) begin
            write_config(pick_floor(), pick_div(), pick_floor(), pick_div());
            set_idling(idle_mode_t'(phase % 4));
            run_random_series(250);
            wait_idle();
        end
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // compare each delivered sample with the oldest prediction
    always @(posedge aclk) begin : result_check
        despiked_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                $error("unexpected sample: day %0d balance %0d", m_out_day,
                       $signed(m_out_balance));
                fail_count++;
            end else begin
                want = expected_out.pop_front();
                if (m_out_day !== want.day) begin
                    $error("out_day: expected %0d, got %0d", want.day, m_out_day);
                    fail_count++;
                end
                if (m_out_balance !== want.bal) begin
                    $error("out_balance: expected %0d, got %0d", $signed(want.bal),
                           $signed(m_out_balance));
                    fail_count++;
                end
                if (m_was_corrected !== want.fixed) begin
                    $error("was_corrected: expected %0d, got %0d", want.fixed,
                           m_was_corrected);
                    fail_count++;
                end
                if (m_out_last !== want.last) begin
                    $error("out_last: expected %0d, got %0d", want.last, m_out_last);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = REG_AGREE_FLOOR;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_day_stamp  = '0;
        s_balance    = '0;
        s_series_end = 1'b0;

        agree_floor_q = AGREE_FLOOR_RST;
        agree_div_q   = AGREE_DIV_RST;
        pulse_floor_q = PULSE_FLOOR_RST;
        pulse_div_q   = PULSE_DIV_RST;
        win_older     = 0;
        win_middle    = 0;
        win_day       = '0;
        win_fill      = SEEN_NONE;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_pause_mid_series();
        test_random_streams();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/tppd_pkg.sv
hw/rtl/tppd_cfg.sv
hw/rtl/tppd_window.sv
hw/rtl/tppd_judge.sv
hw/rtl/tppd_out.sv
hw/rtl/three_point_pulse_despiker_core.sv
dv/testbench.sv
